/* design/assert_macros.svh */
// Assertion helpers used by the checker module cmv_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define CMV_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmv assertion failed");

// Next-cycle implication, gated by reset.
`define CMV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmv assertion failed");

`endif

/* design/cmv_pkg.sv */
package cmv_pkg;

    localparam int ELEM_W          = 16;
    localparam int ACC_W           = 40;
    localparam int VLEN_W          = 8;
    localparam int THR_W           = 15;
    localparam int CFG_W           = 15;
    localparam int CFG_IDX_W       = 1;
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_MAX_DIM     = 128;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VLEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THR  = 1'b1;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 8'd128;
    localparam logic [THR_W-1:0]  THR_RESET  = 15'd27853;

    // result status codes
    localparam logic [2:0] ST_MATCHED  = 3'd0;
    localparam logic [2:0] ST_ENROLLED = 3'd1;
    localparam logic [2:0] ST_NO_MATCH = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_LEN_ERR  = 3'd4;

    typedef struct packed {
        logic                     command;
        logic signed [ELEM_W-1:0] element;
        logic                     last;
    } in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] entry_index;
        logic [6:0] entries_used;
    } out_t;

    // element token walking down the cell row
    typedef struct packed {
        logic                     valid;
        logic signed [ELEM_W-1:0] x;
        logic [VLEN_W-1:0]        pos;
    } tok_t;

    // accumulator control to every cell
    typedef struct packed {
        logic clr;
        logic shift;
    } ctl_t;

endpackage

/* design/cmv_cell.sv */
module cmv_cell
    import cmv_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_DIM     = DEF_MAX_DIM
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tok_t                                 tok_in,
    output tok_t                                 tok_out,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]     cnt,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]     idx,
    input  ctl_t                                 ctl,
    input  logic [ACC_W-1:0]                     dot_in,
    output logic [ACC_W-1:0]                     dot_out
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    logic signed [ELEM_W-1:0]   mem [MAX_DIM];
    logic signed [ELEM_W-1:0]   rd_reg;
    logic signed [ELEM_W-1:0]   x_reg;
    logic signed [2*ELEM_W-1:0] prod_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    tok_t                       tok_reg;
    logic [ACC_W-1:0]           dot_reg;

    // row store: staging write when this cell is the next free row
    always_ff @(posedge clk)
    begin
        if (tok_in.valid && idx == cnt)
        begin
            mem[AW'(tok_in.pos)] <= tok_in.x;
        end
        rd_reg   <= mem[AW'(tok_in.pos)];
        x_reg    <= tok_in.x;
        prod_reg <= x_reg * rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            dot_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            v1_reg  <= tok_in.valid && (idx < cnt);
            v2_reg  <= v1_reg;
            if (ctl.clr)
            begin
                dot_reg <= '0;
            end
            else if (ctl.shift)
            begin
                dot_reg <= dot_in;
            end
            else if (v2_reg)
            begin
                dot_reg <= dot_reg
                    + {{(ACC_W-2*ELEM_W){prod_reg[2*ELEM_W-1]}}, prod_reg};
            end
        end
    end

    assign tok_out = tok_reg;
    assign dot_out = dot_reg;

endmodule

/* design/cmv_smul.sv */
module cmv_smul
    import cmv_pkg::*;
#(
    parameter int AW = ACC_W,
    parameter int BW = ACC_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AW-1:0]    a,
    input  logic [BW-1:0]    b,
    output logic             done,
    output logic [AW+BW-1:0] p
);

    localparam int CW = $clog2(BW+1);

    logic [AW:0]   hi_reg;
    logic [BW-1:0] lo_reg;
    logic [AW-1:0] a_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [AW:0]   sum;

    // one multiplier bit per cycle, shift-add
    assign sum = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= b;
            a_reg  <= a;
        end
        else if (run_reg)
        begin
            hi_reg <= {1'b0, sum[AW:1]};
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(BW);
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = {hi_reg[AW-1:0], lo_reg};

endmodule

/* design/cosine_match_or_enroll_table.sv */
// Channel | Dir | Handshake           | Payload
// --------+-----+---------------------+-----------------------------------------
// in      | in  | in_valid / in_stall | in_t: command, element, last
// out     | out | out_valid/out_stall | out_t: status, entry_index, entries_used
// cfg     | in  | cfg_write           | cfg_index, cfg_data (no read-back)
//
// Each element's token walks the cell row, one cell per cycle, and then
// passes the read/multiply/add stages of the last cell. A closing element
// then forms threshold^2 * query norm and checks the enrolled entries in turn,
// using the shared bit-serial multipliers for those with a positive dot.
// Reset clears counters and control; row stores and norms are not cleared.
// A finished result waits in the output register; the next query streams in.
module cosine_match_or_enroll_table
    import cmv_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_DIM     = DEF_MAX_DIM
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES+1);
    localparam int EI_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int WT_W  = $clog2(MAX_ENTRIES+4);
    localparam int T2_W  = 2*THR_W;
    localparam int TQ_W  = ACC_W + T2_W;
    localparam int RH_W  = TQ_W + ACC_W;
    localparam int LH_W  = 2*ACC_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PROP = 3'd1;
    localparam logic [2:0] S_TQ   = 3'd2;
    localparam logic [2:0] S_TQWT = 3'd3;
    localparam logic [2:0] S_EVRD = 3'd4;
    localparam logic [2:0] S_EVGO = 3'd5;
    localparam logic [2:0] S_EVWT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]              state_reg;
    logic [VLEN_W-1:0]       vl_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [T2_W-1:0]         t2_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [VLEN_W-1:0]       pos_reg;
    logic                    ovr_reg;
    logic [ACC_W-1:0]        qnorm_reg;
    logic signed [ELEM_W-1:0]   xq_reg;
    logic signed [2*ELEM_W-1:0] sq_reg;
    logic                    qv_reg;
    logic                    sv_reg;
    logic                    cmd_reg;
    logic                    last_reg;
    logic [WT_W-1:0]         wait_reg;
    logic [CNT_W-1:0]        e_reg;
    logic [TQ_W-1:0]         tq_reg;
    logic [2:0]              fin_status_reg;
    logic [5:0]              fin_index_reg;
    logic                    out_valid_reg;
    out_t                    out_reg;
    logic [ACC_W-1:0]        norm_rd_reg;
    tok_t                    tok0_reg;
    logic [ACC_W-1:0]        norm_mem [MAX_ENTRIES];

    logic                    in_xfer;
    logic                    elem_ok;
    logic                    out_free;
    logic                    norm_we;
    logic                    len_bad;
    logic                    head_pos;
    logic                    tq_start;
    logic                    ev_start;
    logic                    tq_done;
    logic                    m1_done;
    logic                    m2_done;
    logic [TQ_W-1:0]         tq_p;
    logic [LH_W-1:0]         m1_p;
    logic [RH_W-1:0]         m2_p;
    logic                    hit;
    ctl_t                    ctl;

    tok_t             tok_w [MAX_ENTRIES+1];
    logic [ACC_W-1:0] dot_w [MAX_ENTRIES+1];

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign elem_ok  = !ovr_reg && (pos_reg < vl_reg) && (32'(pos_reg) < MAX_DIM);
    assign out_free = !out_valid_reg || !out_stall;
    assign len_bad  = (vl_reg == '0) || (32'(vl_reg) > MAX_DIM) || (pos_reg != vl_reg);
    // head of the row: cell 0's dot product, positive test
    assign head_pos = !dot_w[0][ACC_W-1] && (dot_w[0] != '0);
    // dot^2 * 2^30 against threshold^2 * both norms, same width on both sides
    assign hit      = {m1_p, {T2_W{1'b0}}} > m2_p;
    assign norm_we  = (state_reg == S_EVRD) && (e_reg >= cnt_reg) && cmd_reg
                      && (32'(cnt_reg) < MAX_ENTRIES);
    assign tq_start = (state_reg == S_TQ);
    assign ev_start = (state_reg == S_EVGO) && head_pos;

    // dot values step one cell towards the head after each miss
    always_comb
    begin
        ctl.clr   = (state_reg == S_OUT) && out_free;
        ctl.shift = ((state_reg == S_EVGO) && !head_pos)
                    || ((state_reg == S_EVWT) && m1_done && !hit);
    end

    assign tok_w[0]           = tok0_reg;
    assign dot_w[MAX_ENTRIES] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        cmv_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .MAX_DIM     (MAX_DIM)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_w[g]),
            .tok_out (tok_w[g+1]),
            .cnt     (cnt_reg),
            .idx     (CNT_W'(g)),
            .ctl     (ctl),
            .dot_in  (dot_w[g+1]),
            .dot_out (dot_w[g])
        );
    end

    // threshold^2 * query norm, once per query
    cmv_smul #(.AW(ACC_W), .BW(T2_W)) u_tq (
        .clk (clk), .rst_n (rst_n), .start (tq_start),
        .a (qnorm_reg), .b (t2_reg), .done (tq_done), .p (tq_p)
    );

    // dot^2
    cmv_smul #(.AW(ACC_W), .BW(ACC_W)) u_m1 (
        .clk (clk), .rst_n (rst_n), .start (ev_start),
        .a (dot_w[0]), .b (dot_w[0]), .done (m1_done), .p (m1_p)
    );

    // threshold^2 * query norm * entry norm
    cmv_smul #(.AW(TQ_W), .BW(ACC_W)) u_m2 (
        .clk (clk), .rst_n (rst_n), .start (ev_start),
        .a (tq_reg), .b (norm_rd_reg), .done (m2_done), .p (m2_p)
    );

    // norm store
    always_ff @(posedge clk)
    begin
        if (norm_we)
        begin
            norm_mem[EI_W'(cnt_reg)] <= qnorm_reg;
        end
        norm_rd_reg <= norm_mem[EI_W'(e_reg)];
    end

    always_ff @(posedge clk)
    begin
        t2_reg <= thr_reg * thr_reg;
        sq_reg <= xq_reg * xq_reg;
        if (in_xfer)
        begin
            xq_reg <= in_data.element;
        end
        if (tq_done)
        begin
            tq_reg <= tq_p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vl_reg         <= VLEN_RESET;
            thr_reg        <= THR_RESET;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            ovr_reg        <= 1'b0;
            qnorm_reg      <= '0;
            qv_reg         <= 1'b0;
            sv_reg         <= 1'b0;
            cmd_reg        <= 1'b0;
            last_reg       <= 1'b0;
            wait_reg       <= '0;
            e_reg          <= '0;
            fin_status_reg <= ST_NO_MATCH;
            fin_index_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            tok0_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_VLEN: vl_reg  <= cfg_data[VLEN_W-1:0];
                    REG_THR:  thr_reg <= cfg_data[THR_W-1:0];
                    default:  ;
                endcase
            end

            // query norm pipeline: square, then accumulate
            qv_reg         <= in_xfer && elem_ok;
            sv_reg         <= qv_reg;
            if (sv_reg)
            begin
                qnorm_reg <= qnorm_reg + {{(ACC_W-2*ELEM_W){1'b0}}, sq_reg};
            end

            // token lives for one cycle unless a new element is launched
            if (!(in_xfer && elem_ok))
            begin
                tok0_reg.valid <= 1'b0;
            end

            // a result leaving while the next one is loaded is handled in S_OUT
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        cmd_reg  <= in_data.command;
                        last_reg <= in_data.last;
                        if (elem_ok)
                        begin
                            tok0_reg <= '{valid: 1'b1, x: in_data.element, pos: pos_reg};
                            pos_reg  <= pos_reg + 1'b1;
                            wait_reg <= WT_W'(MAX_ENTRIES + 3);
                            state_reg <= S_PROP;
                        end
                        else
                        begin
                            ovr_reg <= 1'b1;
                            if (in_data.last)
                            begin
                                fin_status_reg <= ST_LEN_ERR;
                                fin_index_reg  <= '0;
                                state_reg      <= S_OUT;
                            end
                        end
                    end
                end
                S_PROP:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_reg <= wait_reg - 1'b1;
                    end
                    else if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (len_bad)
                    begin
                        fin_status_reg <= ST_LEN_ERR;
                        fin_index_reg  <= '0;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_TQ;
                    end
                end
                S_TQ:
                begin
                    e_reg     <= '0;
                    state_reg <= S_TQWT;
                end
                S_TQWT:
                begin
                    if (tq_done)
                    begin
                        state_reg <= S_EVRD;
                    end
                end
                S_EVRD:
                begin
                    if (e_reg < cnt_reg)
                    begin
                        state_reg <= S_EVGO;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        if (!cmd_reg)
                        begin
                            fin_status_reg <= ST_NO_MATCH;
                            fin_index_reg  <= '0;
                        end
                        else if (32'(cnt_reg) >= MAX_ENTRIES)
                        begin
                            fin_status_reg <= ST_FULL;
                            fin_index_reg  <= '0;
                        end
                        else
                        begin
                            fin_status_reg <= ST_ENROLLED;
                            fin_index_reg  <= 6'(cnt_reg);
                            cnt_reg        <= cnt_reg + 1'b1;
                        end
                    end
                end
                S_EVGO:
                begin
                    if (head_pos)
                    begin
                        state_reg <= S_EVWT;
                    end
                    else
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= S_EVRD;
                    end
                end
                S_EVWT:
                begin
                    if (m1_done && m2_done)
                    begin
                        if (hit)
                        begin
                            fin_status_reg <= ST_MATCHED;
                            fin_index_reg  <= 6'(e_reg);
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            e_reg     <= e_reg + 1'b1;
                            state_reg <= S_EVRD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= '{status: fin_status_reg,
                                           entry_index: fin_index_reg,
                                           entries_used: 7'(cnt_reg)};
                        out_valid_reg <= 1'b1;
                        qnorm_reg     <= '0;
                        pos_reg       <= '0;
                        ovr_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* design/cmv_chk.sv */
`include "assert_macros.svh"

module cmv_chk
    import cmv_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input out_t out_data
);

    `CMV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `CMV_ASSERT_HOLDS(a_status_range, out_valid, out_data.status <= ST_LEN_ERR)
    `CMV_ASSERT_HOLDS(a_index_zero, out_valid && (out_data.status == ST_NO_MATCH || out_data.status == ST_FULL || out_data.status == ST_LEN_ERR), out_data.entry_index == 6'd0)
    `CMV_ASSERT_HOLDS(a_enrol_last, out_valid && out_data.status == ST_ENROLLED, {1'b0, out_data.entry_index} == out_data.entries_used - 7'd1)
    `CMV_ASSERT_HOLDS(a_used_max, out_valid, 32'(out_data.entries_used) <= MAX_ENTRIES)

endmodule

bind cosine_match_or_enroll_table cmv_chk #(.MAX_ENTRIES(MAX_ENTRIES)) u_cmv_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

/* tb/tb_cosine_match_or_enroll_table.sv */
module tb_cosine_match_or_enroll_table;
    import cmv_pkg::*;

    localparam int ENTRIES    = DEF_MAX_ENTRIES;
    localparam int DIM        = DEF_MAX_DIM;
    localparam int IDLE_LIMIT = 20000;  // covers the slowest close plus the long hold-off
    localparam int DRAIN      = 200;

    typedef enum int {
        Q_COPY, Q_NOISY, Q_NEGATED, Q_RANDOM, Q_ZERO, Q_EXTREME, Q_BAD_LEN
    } query_kind_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    cosine_match_or_enroll_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: the table as the block should hold it
    // ------------------------------------------------------------------
    int unsigned             vlen_reg = VLEN_RESET;
    logic [THR_W-1:0]        thr_reg  = THR_RESET;
    logic signed [ELEM_W-1:0] rows [ENTRIES][DIM];
    logic [ACC_W-1:0]        row_norms [ENTRIES];
    int                      used_rows = 0;
    logic signed [ACC_W-1:0] dots [ENTRIES];
    logic [ACC_W-1:0]        qnorm = '0;
    int                      qpos = 0;
    bit                      overrun = 1'b0;

    out_t expected_results [$];
    logic signed [ELEM_W-1:0] qbuf [$];   // query being built for sending

    int  mismatches = 0;
    bit  in_take = 1'b0;
    bit  out_take = 1'b0;
    int  hold_left = 0;       // long receiver hold-off, counted by the stall process
    int  burst_left = 0;
    bit  sender_gaps = 1'b1;

    // Cosine test without root or division:
    // dot > 0 and dot^2 * 2^30 > thr^2 * norm_entry * norm_query
    function automatic bit entry_similar(int e);
        logic [127:0] mag;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] nrm_e;
        logic [127:0] nrm_q;
        logic [127:0] t2;
        if (dots[e] <= 0)
            return 1'b0;
        mag   = {88'b0, dots[e]};
        lhs   = (mag * mag) << 30;
        nrm_e = {88'b0, row_norms[e]};
        nrm_q = {88'b0, qnorm};
        t2    = {113'b0, thr_reg} * {113'b0, thr_reg};
        rhs   = nrm_e * nrm_q * t2;
        return lhs > rhs;
    endfunction

    // Advance the predicted table by one element; closing elements queue a result.
    task automatic table_take_element(in_t it);
        logic signed [31:0] prod;
        out_t               res;
        bit                 found;
        begin
            found = 1'b0;
            if (!overrun && qpos < vlen_reg && qpos < DIM) begin
                for (int e = 0; e < used_rows; e++) begin
                    prod = it.element * rows[e][qpos];
                    dots[e] = dots[e] + {{8{prod[31]}}, prod};
                end
                prod = it.element * it.element;
                qnorm = qnorm + {8'b0, prod};
                if (used_rows < ENTRIES)
                    rows[used_rows][qpos] = it.element;   // staged, committed on enroll
                qpos++;
            end else begin
                overrun = 1'b1;
            end
            if (it.last) begin
                res = '0;
                if (overrun || vlen_reg == 0 || vlen_reg > DIM || qpos != vlen_reg) begin
                    res.status = ST_LEN_ERR;
                end else begin
                    for (int e = 0; e < used_rows && !found; e++)
                        if (entry_similar(e)) begin
                            found = 1'b1;
                            res.entry_index = 6'(e);
                        end
                    if (found)
                        res.status = ST_MATCHED;
                    else if (!it.command)
                        res.status = ST_NO_MATCH;
                    else if (used_rows >= ENTRIES)
                        res.status = ST_FULL;
                    else begin
                        res.entry_index = 6'(used_rows);
                        row_norms[used_rows] = qnorm;
                        used_rows++;
                        res.status = ST_ENROLLED;
                    end
                end
                res.entries_used = 7'(used_rows);
                expected_results.insert(expected_results.size(), res);
                for (int e = 0; e < ENTRIES; e++)
                    dots[e] = '0;
                qnorm = '0;
                qpos = 0;
                overrun = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Handshake sampling, result checking and watchdog.
    // Stall and valid only change at rising edges, so the falling edge
    // sees exactly what the next rising edge will act on.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        in_take  = rst_n && in_valid && !in_stall;
        out_take = rst_n && out_valid && !out_stall;
        if (out_take) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d index=%0d used=%0d",
                             out_data.status, out_data.entry_index, out_data.entries_used);
            end else begin
                out_t want;
                want = expected_results.pop_front();
                if (out_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp status=%0d index=%0d used=%0d, got status=%0d index=%0d used=%0d",
                                 want.status, want.entry_index, want.entries_used,
                                 out_data.status, out_data.entry_index, out_data.entries_used);
                end
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_take || out_take)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: the stall mode is redrawn at random by a mode counter; a requested
    // hold-off overrides it.
    int stall_mode = 0;
    int mode_cycles = 0;
    int pattern_step = 0;
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 80);
                default: out_stall <= (pattern_step % 7 < 3);
            endcase
        end
        pattern_step++;
        if (++mode_cycles >= 300) begin
            mode_cycles = 0;
            stall_mode  = $urandom_range(0, 3);
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------
    task automatic send_item(in_t it);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = sender_gaps ? $urandom_range(0, 6) : 0;
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid <= 1'b1;
            in_data  <= it;
            do
                @(posedge clk);
            while (!in_take);
            table_take_element(it);
        end
    endtask

    task automatic send_query(bit cmd);
        in_t it;
        begin
            for (int i = 0; i < qbuf.size(); i++) begin
                it.element = qbuf[i];
                it.last    = (i == qbuf.size() - 1);
                it.command = it.last ? cmd : 1'($urandom);
                send_item(it);
            end
        end
    endtask

    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (100) @(posedge clk);
        end
    endtask

    // One write, then cfg_write drops low before the task returns, so back-to-back
    // writes never meet in the same time step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
            cfg_write <= 1'b0;
            if (idx == REG_VLEN)
                vlen_reg = value[VLEN_W-1:0];
            else
                thr_reg = value[THR_W-1:0];
            @(posedge clk);
        end
    endtask

    // Fills qbuf with one query of the given kind at vector length len.
    task automatic build_query(query_kind_e kind, int len);
        int src;
        int n;
        begin
            qbuf.delete();
            if (used_rows == 0 && kind inside {Q_COPY, Q_NOISY, Q_NEGATED})
                kind = Q_RANDOM;
            src = (used_rows > 0) ? $urandom_range(0, used_rows - 1) : 0;
            n = len;
            if (kind == Q_BAD_LEN)
                n = (len > 1 && $urandom_range(0, 1)) ? $urandom_range(1, len - 1)
                                                      : len + $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                case (kind)
                    Q_COPY:    qbuf.insert(qbuf.size(), rows[src][i]);
                    Q_NOISY:   qbuf.insert(qbuf.size(),
                                           rows[src][i] + 16'($urandom_range(0, 64)) - 16'sd32);
                    Q_NEGATED: qbuf.insert(qbuf.size(), -rows[src][i]);
                    Q_ZERO:    qbuf.insert(qbuf.size(), '0);
                    Q_EXTREME: qbuf.insert(qbuf.size(),
                                           $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
                    default:   qbuf.insert(qbuf.size(), 16'($urandom));
                endcase
            end
        end
    endtask

    task automatic random_queries(int n_items, int enroll_pct);
        int sent;
        int pick;
        query_kind_e kind;
        begin
            sent = 0;
            sender_gaps = 1'b1;
            while (sent < n_items) begin
                pick = $urandom_range(0, 99);
                if      (pick < 25) kind = Q_COPY;
                else if (pick < 40) kind = Q_NOISY;
                else if (pick < 47) kind = Q_NEGATED;
                else if (pick < 77) kind = Q_RANDOM;
                else if (pick < 82) kind = Q_ZERO;
                else if (pick < 90) kind = Q_EXTREME;
                else                kind = Q_BAD_LEN;
                build_query(kind, vlen_reg);
                if (($urandom_range(0, 49) == 0))
                    sender_gaps = !sender_gaps;   // stretches with no sender gaps
                send_query($urandom_range(0, 99) < enroll_pct);
                sent += qbuf.size();
            end
            sender_gaps = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lengths the block must reject outright: zero, beyond the row size,
    // and a short query at the reset length.
    task automatic test_length_limits();
        begin
            build_query(Q_RANDOM, 3);
            send_query(1'b1);
            wait_idle();
            write_reg(REG_VLEN, 15'h7fff);   // 255 in the register
            build_query(Q_RANDOM, 2);
            send_query(1'b1);
            wait_idle();
            write_reg(REG_VLEN, '0);
            build_query(Q_EXTREME, 2);
            send_query(1'b1);
            build_query(Q_RANDOM, 1);
            send_query(1'b0);
            wait_idle();
        end
    endtask

    // Full-size rows at the largest length; rows stay valid for all
    // shorter lengths used later, so the length only ever goes down.
    task automatic test_full_rows();
        begin
            write_reg(REG_VLEN, 15'(DIM));
            build_query(Q_RANDOM, DIM);
            send_query(1'b1);
            build_query(Q_COPY, DIM);
            send_query(1'b0);
            build_query(Q_RANDOM, DIM);
            send_query(1'b1);
            wait_idle();
        end
    endtask

    // Element extremes, match versus enroll, zero norm, short and long query.
    task automatic test_special_cases();
        begin
            write_reg(REG_VLEN, 15'd4);
            write_reg(REG_THR, 15'(THR_RESET));
            qbuf = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
            send_query(1'b1);                 // enrolled
            send_query(1'b0);                 // matches itself
            qbuf = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
            send_query(1'b0);                 // opposite direction
            qbuf = '{16'sh0, 16'sh0, 16'sh0, 16'sh0};
            send_query(1'b1);                 // zero norm, enrolled, never matches later
            qbuf = '{16'sh1234, 16'shedcb};
            send_query(1'b1);                 // too short
            qbuf = '{16'sh1, 16'sh2, 16'sh3, 16'sh4, 16'sh5};
            send_query(1'b1);                 // too long
            wait_idle();
        end
    endtask

    task automatic test_random_mix();
        begin
            random_queries(350, 60);
            wait_idle();
            write_reg(REG_THR, 15'h7fff);
            random_queries(250, 60);
            wait_idle();
            write_reg(REG_VLEN, 15'd3);
            write_reg(REG_THR, '0);         // any positive dot matches
            random_queries(250, 50);
            wait_idle();
        end
    endtask

    // Near-exact threshold at length 2: random queries enroll until the
    // table is full, then unmatched enrolls report full.
    task automatic test_table_full();
        int extra;
        begin
            write_reg(REG_VLEN, 15'd2);
            write_reg(REG_THR, 15'h7fff);
            extra = 0;
            while (extra < 8) begin
                if (used_rows >= ENTRIES)
                    extra++;
                build_query(Q_RANDOM, 2);
                send_query(1'b1);
            end
            build_query(Q_RANDOM, 2);
            send_query(1'b0);
            wait_idle();
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the result
    // register fills and the input stalls.
    task automatic test_backpressure();
        begin
            write_reg(REG_VLEN, 15'd1);
            write_reg(REG_THR, 15'd16384);
            random_queries(100, 50);
            hold_left = 600;
            sender_gaps = 1'b0;
            for (int i = 0; i < 40; i++) begin
                build_query(Q_RANDOM, 1);
                send_query(1'b1);
            end
            sender_gaps = 1'b1;
            wait_idle();
        end
    endtask

    initial
    begin
        for (int e = 0; e < ENTRIES; e++) begin
            dots[e] = '0;
            row_norms[e] = '0;
            for (int i = 0; i < DIM; i++)
                rows[e][i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_length_limits();
        test_full_rows();
        test_special_cases();
        test_random_mix();
        test_table_full();
        test_backpressure();

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
